/* rtl/core/broadcast_index_mapper_top_assert.svh */
// Assertion macros for the broadcast index mapper top level.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef BROADCAST_INDEX_MAPPER_TOP_ASSERT_SVH
`define BROADCAST_INDEX_MAPPER_TOP_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define BIM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset.
`define BIM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bim_pkg.sv */
// Shared constants for the broadcast index mapper.
// No dependencies.
`timescale 1ns / 1ps
package bim_pkg;
  localparam int MAX_RANK_DEF   = 8;
  localparam int DIM_BITS_DEF   = 16;
  localparam int INDEX_BITS_DEF = 32;

  localparam int OUT_INDEX_W = 32;
  localparam int IN_INDEX_W  = 32;
  localparam int RANK_REG_W  = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;
  localparam int REG_SEL_W   = 3;

  // Restoring division: bits per stage and stages per axis.
  localparam int DIV_STEPS  = 8;
  localparam int DIV_STAGES = OUT_INDEX_W / DIV_STEPS;

  localparam logic [REG_SEL_W-1:0] REG_OUT_RANK = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_IN_RANK  = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_OUT_LO   = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_OUT_HI   = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_IN_LO    = 3'd4;
  localparam logic [REG_SEL_W-1:0] REG_IN_HI    = 3'd5;

  localparam logic [RANK_REG_W-1:0] RANK_RST = 4'd1;
  localparam logic [CFG_DATA_W-1:0] DIMS_RST = 64'h0001_0001_0001_0001;
endpackage

/* rtl/core/bim_div_stage.sv */
// One pipeline stage of the per-axis restoring divider (DIV_STEPS bits).
// Depends on bim_pkg.
`timescale 1ns / 1ps
module bim_div_stage #(
  parameter int       MAX_RANK = bim_pkg::MAX_RANK_DEF,
  parameter int       DIM_BITS = bim_pkg::DIM_BITS_DEF,
  parameter int       AXIS     = 0,
  parameter bit       FIRST    = 1'b0,
  parameter bit       LAST     = 1'b0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  input  logic                                   active_i,
  input  logic [DIM_BITS-1:0]                    dim_i,
  input  logic [bim_pkg::OUT_INDEX_W-1:0]        q_i,
  input  logic [DIM_BITS:0]                      r_i,
  input  logic [MAX_RANK-1:0][DIM_BITS-1:0]      coord_i,
  output logic [bim_pkg::OUT_INDEX_W-1:0]        q_o,
  output logic [DIM_BITS:0]                      r_o,
  output logic [MAX_RANK-1:0][DIM_BITS-1:0]      coord_o
);
  localparam int QW = bim_pkg::OUT_INDEX_W;

  logic                                valid_q;
  logic [QW-1:0]                       q_d, q_q;
  logic [DIM_BITS:0]                   r_d, r_q;
  logic [MAX_RANK-1:0][DIM_BITS-1:0]   coord_d, coord_q;

  always_comb begin
    logic [DIM_BITS:0] rem;
    logic [DIM_BITS:0] sh;
    logic [QW-1:0]     quo;
    rem = FIRST ? '0 : r_i;
    quo = q_i;
    for (int s = 0; s < bim_pkg::DIV_STEPS; s++) begin
      sh = {rem[DIM_BITS-1:0], quo[QW-1]};
      if (sh >= {1'b0, dim_i}) begin
        rem = sh - {1'b0, dim_i};
        quo = {quo[QW-2:0], 1'b1};
      end else begin
        rem = sh;
        quo = {quo[QW-2:0], 1'b0};
      end
    end
    coord_d = coord_i;
    if (!active_i) begin
      q_d = q_i;
      r_d = r_i;
    end else begin
      q_d = quo;
      r_d = rem;
      if (LAST) begin
        // zero-sized axis: coordinate 0 and nothing left to split
        if (dim_i == '0) begin
          coord_d[AXIS] = '0;
          q_d           = '0;
        end else begin
          coord_d[AXIS] = rem[DIM_BITS-1:0];
        end
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      q_q     <= q_d;
      r_q     <= r_d;
      coord_q <= coord_d;
    end
  end

  assign valid_o = valid_q;
  assign q_o     = q_q;
  assign r_o     = r_q;
  assign coord_o = coord_q;
endmodule

/* rtl/core/bim_mac_stage.sv */
// One recomposition stage: acc = acc * dim + coord for one input axis.
// Depends on bim_pkg.
`timescale 1ns / 1ps
module bim_mac_stage #(
  parameter int MAX_RANK   = bim_pkg::MAX_RANK_DEF,
  parameter int DIM_BITS   = bim_pkg::DIM_BITS_DEF,
  parameter int INDEX_BITS = bim_pkg::INDEX_BITS_DEF,
  parameter int RANK_W     = $clog2(MAX_RANK + 1),
  parameter int AXIS       = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  output logic                                valid_o,
  input  logic                                ready_i,
  input  logic                                active_i,
  input  logic [DIM_BITS-1:0]                 dim_i,
  input  logic [RANK_W-1:0]                   orank_i,
  input  logic [RANK_W-1:0]                   irank_i,
  input  logic [MAX_RANK-1:0][DIM_BITS-1:0]   coord_i,
  input  logic [INDEX_BITS-1:0]               acc_i,
  input  logic                                ovf_i,
  output logic [MAX_RANK-1:0][DIM_BITS-1:0]   coord_o,
  output logic [INDEX_BITS-1:0]               acc_o,
  output logic                                ovf_o
);
  localparam int SW = INDEX_BITS + DIM_BITS + 1;

  logic                              valid_q;
  logic [INDEX_BITS-1:0]             acc_d, acc_q;
  logic                              ovf_d, ovf_q;
  logic [MAX_RANK-1:0][DIM_BITS-1:0] coord_q;

  always_comb begin
    logic [RANK_W:0]              base;
    logic [RANK_W:0]              j;
    logic [DIM_BITS-1:0]          c;
    logic [SW-1:0]                sum;
    base = (RANK_W + 1)'(AXIS) + {1'b0, orank_i};
    j    = base - {1'b0, irank_i};
    c    = '0;
    // axes aligned to the trailing output axes; size-1 axes broadcast
    if (dim_i != DIM_BITS'(1) && base >= {1'b0, irank_i}) begin
      for (int jj = 0; jj < MAX_RANK; jj++) begin
        if (j == (RANK_W + 1)'(jj)) c = coord_i[jj];
      end
    end
    sum = SW'(acc_i) * SW'(dim_i) + SW'(c);
    if (active_i) begin
      acc_d = sum[INDEX_BITS-1:0];
      ovf_d = ovf_i || (sum[SW-1:INDEX_BITS] != '0);
    end else begin
      acc_d = acc_i;
      ovf_d = ovf_i;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      coord_q <= coord_i;
    end
  end

  assign valid_o = valid_q;
  assign acc_o   = acc_q;
  assign ovf_o   = ovf_q;
  assign coord_o = coord_q;
endmodule

/* rtl/core/broadcast_index_mapper_top.sv */
// Broadcast index mapper: a 4-stage restoring divider per output axis followed
// by one multiply-add stage per input axis. Throughput one item per clock while
// out_stall_i is low; stages advance independently,
// so bubbles close up behind a stalled result.
// Reset clears all stage valids and loads ranks 1 and all dimensions 1.
// Depends on bim_pkg, bim_div_stage, bim_mac_stage and the assertion header.
`timescale 1ns / 1ps
`include "broadcast_index_mapper_top_assert.svh"
module broadcast_index_mapper_top #(
  parameter int MAX_RANK   = bim_pkg::MAX_RANK_DEF,
  parameter int DIM_BITS   = bim_pkg::DIM_BITS_DEF,
  parameter int INDEX_BITS = bim_pkg::INDEX_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bim_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [bim_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [bim_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  // input items
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bim_pkg::OUT_INDEX_W-1:0]    out_index_i,
  // result items
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bim_pkg::IN_INDEX_W-1:0]     in_index_o,
  output logic                               index_overflow_o
);
  localparam int RANK_W = $clog2(MAX_RANK + 1);
  localparam int QW     = bim_pkg::OUT_INDEX_W;
  localparam int DW_REG = bim_pkg::CFG_DATA_W;
  localparam int ND     = MAX_RANK * bim_pkg::DIV_STAGES;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write them only while idle (the block
  // does not enforce this), so every stage reads them directly rather than carrying a copy alongside each item.
  // ---------------------------------------------------------------------------
  logic [bim_pkg::RANK_REG_W-1:0] out_rank_q, in_rank_q;
  logic [DW_REG-1:0]              out_lo_q, out_hi_q, in_lo_q, in_hi_q;
  logic [bim_pkg::REG_SEL_W-1:0]  reg_sel;
  logic                           wr_en;

  assign reg_sel = paddr[bim_pkg::CFG_ADDR_W-1:bim_pkg::CFG_ADDR_W-bim_pkg::REG_SEL_W];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_rank_q <= bim_pkg::RANK_RST;
      in_rank_q  <= bim_pkg::RANK_RST;
      out_lo_q   <= bim_pkg::DIMS_RST;
      out_hi_q   <= bim_pkg::DIMS_RST;
      in_lo_q    <= bim_pkg::DIMS_RST;
      in_hi_q    <= bim_pkg::DIMS_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        bim_pkg::REG_OUT_RANK: out_rank_q <= pwdata[bim_pkg::RANK_REG_W-1:0];
        bim_pkg::REG_IN_RANK:  in_rank_q  <= pwdata[bim_pkg::RANK_REG_W-1:0];
        bim_pkg::REG_OUT_LO:   out_lo_q   <= pwdata;
        bim_pkg::REG_OUT_HI:   out_hi_q   <= pwdata;
        bim_pkg::REG_IN_LO:    in_lo_q    <= pwdata;
        bim_pkg::REG_IN_HI:    in_hi_q    <= pwdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bim_pkg::REG_OUT_RANK: prdata = DW_REG'(out_rank_q);
      bim_pkg::REG_IN_RANK:  prdata = DW_REG'(in_rank_q);
      bim_pkg::REG_OUT_LO:   prdata = out_lo_q;
      bim_pkg::REG_OUT_HI:   prdata = out_hi_q;
      bim_pkg::REG_IN_LO:    prdata = in_lo_q;
      bim_pkg::REG_IN_HI:    prdata = in_hi_q;
      default:               prdata = '0;
    endcase
  end

  // Saturate ranks to MAX_RANK.
  logic [RANK_W-1:0] orank, irank;
  assign orank = (out_rank_q > bim_pkg::RANK_REG_W'(MAX_RANK)) ?
                 RANK_W'(MAX_RANK) : RANK_W'(out_rank_q);
  assign irank = (in_rank_q > bim_pkg::RANK_REG_W'(MAX_RANK)) ?
                 RANK_W'(MAX_RANK) : RANK_W'(in_rank_q);

  // Unpack dimension fields; bits past the top of a register read as zero.
  logic [MAX_RANK-1:0][DIM_BITS-1:0] odim, idim;
  for (genvar k = 0; k < MAX_RANK; k++) begin : g_dims
    localparam int SH = (k % 4) * DIM_BITS;
    if (SH >= DW_REG) begin : g_zero
      assign odim[k] = '0;
      assign idim[k] = '0;
    end else begin : g_field
      logic [2*DW_REG-1:0] oext, iext;
      assign oext    = {{DW_REG{1'b0}}, (k < 4) ? out_lo_q : out_hi_q};
      assign iext    = {{DW_REG{1'b0}}, (k < 4) ? in_lo_q : in_hi_q};
      assign odim[k] = oext[SH +: DIM_BITS];
      assign idim[k] = iext[SH +: DIM_BITS];
    end
  end

  // ---------------------------------------------------------------------------
  // Split: innermost axis handled first in the chain, outermost last, so the
  // chain walks axes from MAX_RANK-1 down to 0. Axes at or above the output
  // rank pass the item through untouched.
  // ---------------------------------------------------------------------------
  logic                              dv [ND+1];
  logic                              dr [ND+1];
  logic [QW-1:0]                     dq [ND+1];
  logic [DIM_BITS:0]                 drem [ND+1];
  logic [MAX_RANK-1:0][DIM_BITS-1:0] dc [ND+1];

  assign dv[0]      = in_valid_i;
  assign in_stall_o = !dr[0];
  assign dq[0]      = out_index_i;
  assign drem[0]    = '0;
  assign dc[0]      = '0;

  for (genvar s = 0; s < MAX_RANK; s++) begin : g_axis
    localparam int AX = MAX_RANK - 1 - s;
    logic act;
    assign act = orank > RANK_W'(AX);
    for (genvar t = 0; t < bim_pkg::DIV_STAGES; t++) begin : g_step
      localparam int N = s * bim_pkg::DIV_STAGES + t;
      bim_div_stage #(
        .MAX_RANK (MAX_RANK),
        .DIM_BITS (DIM_BITS),
        .AXIS     (AX),
        .FIRST    (t == 0),
        .LAST     (t == bim_pkg::DIV_STAGES - 1)
      ) u_div (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .valid_i  (dv[N]),
        .ready_o  (dr[N]),
        .valid_o  (dv[N+1]),
        .ready_i  (dr[N+1]),
        .active_i (act),
        .dim_i    (odim[AX]),
        .q_i      (dq[N]),
        .r_i      (drem[N]),
        .coord_i  (dc[N]),
        .q_o      (dq[N+1]),
        .r_o      (drem[N+1]),
        .coord_o  (dc[N+1])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Recompose: one multiply-add per input axis, outermost first.
  // ---------------------------------------------------------------------------
  logic                              mv [MAX_RANK+1];
  logic                              mr [MAX_RANK+1];
  logic [MAX_RANK-1:0][DIM_BITS-1:0] mc [MAX_RANK+1];
  logic [INDEX_BITS-1:0]             macc [MAX_RANK+1];
  logic                              movf [MAX_RANK+1];

  assign mv[0]   = dv[ND];
  assign dr[ND]  = mr[0];
  assign mc[0]   = dc[ND];
  assign macc[0] = '0;
  assign movf[0] = 1'b0;

  for (genvar i = 0; i < MAX_RANK; i++) begin : g_mac
    logic act;
    assign act = irank > RANK_W'(i);
    bim_mac_stage #(
      .MAX_RANK   (MAX_RANK),
      .DIM_BITS   (DIM_BITS),
      .INDEX_BITS (INDEX_BITS),
      .RANK_W     (RANK_W),
      .AXIS       (i)
    ) u_mac (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (mv[i]),
      .ready_o  (mr[i]),
      .valid_o  (mv[i+1]),
      .ready_i  (mr[i+1]),
      .active_i (act),
      .dim_i    (idim[i]),
      .orank_i  (orank),
      .irank_i  (irank),
      .coord_i  (mc[i]),
      .acc_i    (macc[i]),
      .ovf_i    (movf[i]),
      .coord_o  (mc[i+1]),
      .acc_o    (macc[i+1]),
      .ovf_o    (movf[i+1])
    );
  end

  // The last multiply-add register doubles as the output register.
  assign mr[MAX_RANK]     = !out_stall_i;
  assign out_valid_o      = mv[MAX_RANK];
  assign in_index_o       = bim_pkg::IN_INDEX_W'(macc[MAX_RANK]);
  assign index_overflow_o = movf[MAX_RANK];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The input side can only be held back by a result waiting at the output.
  `BIM_ASSERT_IMPLY(a_stall_needs_result, in_stall_o, out_valid_o && out_stall_i, "input stalled with no waiting result")
  // A rank-0 input tensor always maps to index 0 with no overflow.
  `BIM_ASSERT_IMPLY(a_rank0_zero, out_valid_o && irank == '0, in_index_o == '0 && !index_overflow_o, "rank-0 input gave non-zero index")
  // A result taken without a new one behind it leaves the output empty.
  `BIM_ASSERT_NEXT(a_drain, out_valid_o && !out_stall_i && !mv[MAX_RANK-1], !out_valid_o, "result repeated at the output")
endmodule
